// ===== hw/rtl/terrain_geodata_block_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the terrain geodata block decoder
// Clocked concurrent checks. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_GEODATA_BLOCK_DECODER_MACROS_SVH
`define TERRAIN_GEODATA_BLOCK_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Check held off while reset is asserted
`define TGBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that also runs during reset
`define TGBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TGBD_ASSERT(lbl, clk, rstn, prop, msg)
`define TGBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/tgbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Terrain geodata block decoder package
// Geometry constants, parser phase codes, beat payload types and helpers.
// ----------------------------------------------------------------------------
package tgbd_pkg;

    // Region geometry
    localparam int BLOCKS_PER_SIDE = 256;
    localparam int BLK_W           = (BLOCKS_PER_SIDE > 1) ? $clog2(BLOCKS_PER_SIDE) : 1;
    localparam int CELLS_PER_BLOCK = 64;
    localparam int CELL_W          = $clog2(CELLS_PER_BLOCK);

    localparam logic [BLK_W-1:0]  BLK_LAST  = BLK_W'(BLOCKS_PER_SIDE - 1);
    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS_PER_BLOCK - 1);

    // Block type bytes and held type codes
    localparam logic [7:0] TYPE_BYTE_FLAT    = 8'd0;
    localparam logic [7:0] TYPE_BYTE_COMPLEX = 8'd1;

    typedef enum logic [1:0] {
        BT_FLAT    = 2'd0,
        BT_COMPLEX = 2'd1,
        BT_MULTI   = 2'd2
    } blk_type_t;

    localparam logic [3:0] NSWE_FLAT = 4'hF;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_TYPE    = 7'b0000001,
        PH_FLAT_LO = 7'b0000010,
        PH_FLAT_HI = 7'b0000100,
        PH_WORD_LO = 7'b0001000,
        PH_WORD_HI = 7'b0010000,
        PH_COUNT   = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [10:0]        cell_x;
        logic [10:0]        cell_z;
        logic [7:0]         layer_index;
        logic signed [15:0] height;
        logic [3:0]         nswe_bits;
        logic               last;
    } out_beat_t;

    // Word height: keep bits 15:4, arithmetic shift right by one
    function automatic logic [15:0] decode_height(input logic [15:0] word);
        logic [15:0] m;
        m = word & 16'hFFF0;
        return {m[15], m[15:1]};
    endfunction

    // Cell coordinate: block index times 8 plus cell offset
    function automatic logic [10:0] cell_coord(input logic [BLK_W-1:0] blk,
                                               input logic [2:0] sub);
        return 11'({blk, 3'b000}) | 11'(sub);
    endfunction

endpackage

// ===== hw/rtl/terrain_geodata_block_decoder.sv =====
// ----------------------------------------------------------------------------
// Terrain geodata block decoder
// Parses a region file byte stream and emits one record per cell layer.
//
//   Channel | Dir | Beat                          | Handshake
//   s_      | in  | one file byte, restart flag   | s_valid / s_ready
//   m_      | out | one cell layer record         | m_valid / m_ready
//
// One byte is parsed per cycle; its record lands in the output register on
// the accepting edge, so a byte is taken every cycle that m_ready holds and
// no burst runs. A flat block's second height byte starts a 64-record run,
// 63 from the burst counter; s_ready stays low until the last one is loaded.
// Reset (aresetn, synchronous) sets the parser to expect a block type.
// ----------------------------------------------------------------------------
`include "terrain_geodata_block_decoder_macros.svh"

module terrain_geodata_block_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tgbd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tgbd_pkg::out_beat_t m_data
);

    // Parser state
    tgbd_pkg::phase_t                 phase_reg, phase_next;
    tgbd_pkg::blk_type_t              type_reg, type_next;
    logic [tgbd_pkg::BLK_W-1:0]       row_reg, row_next;
    logic [tgbd_pkg::BLK_W-1:0]       col_reg, col_next;
    logic [tgbd_pkg::CELL_W-1:0]      cell_reg, cell_next;
    logic [7:0]                       rem_reg, rem_next;
    logic [7:0]                       layer_reg, layer_next;
    logic [7:0]                       low_reg, low_next;

    // Output register and flat-block burst
    logic                             m_valid_reg;
    tgbd_pkg::out_beat_t              m_data_reg;
    logic                             burst_reg, burst_next;
    logic [tgbd_pkg::CELL_W-1:0]      bcell_reg, bcell_next;
    logic [15:0]                      bheight_reg, bheight_next;
    logic [tgbd_pkg::BLK_W-1:0]       brow_reg, brow_next;
    logic [tgbd_pkg::BLK_W-1:0]       bcol_reg, bcol_next;

    logic                             s_fire, m_fire;
    logic                             rec_load;
    tgbd_pkg::out_beat_t              rec;
    tgbd_pkg::out_beat_t              burst_rec;

    // Effective state after an optional restart
    tgbd_pkg::phase_t                 cur_phase;
    logic [tgbd_pkg::BLK_W-1:0]       cur_row, cur_col;

    // Next-block outcome
    tgbd_pkg::phase_t                 nb_phase;
    logic [tgbd_pkg::BLK_W-1:0]       nb_row, nb_col;

    logic [15:0]                      word;
    logic [7:0]                       rem_dec;
    logic                             cell_end;

    // Handshake
    assign s_ready = (!m_valid_reg || m_ready) && !burst_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid_reg && m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Restart clears the parser before this byte is used
    assign cur_phase = s_data.restart ? tgbd_pkg::PH_TYPE : phase_reg;
    assign cur_row   = s_data.restart ? '0 : row_reg;
    assign cur_col   = s_data.restart ? '0 : col_reg;

    assign word     = {s_data.data_byte, low_reg};
    assign rem_dec  = (rem_reg != 8'd0) ? rem_reg - 8'd1 : 8'd0;
    assign cell_end = (cell_reg == tgbd_pkg::CELL_LAST);

    // Block advance: column inner, row outer
    always_comb begin
        nb_row   = cur_row;
        nb_col   = cur_col + 1'b1;
        nb_phase = tgbd_pkg::PH_TYPE;
        if (cur_col == tgbd_pkg::BLK_LAST) begin
            nb_col = '0;
            nb_row = cur_row + 1'b1;
            if (cur_row == tgbd_pkg::BLK_LAST) begin
                nb_phase = tgbd_pkg::PH_DONE;
            end
        end
    end

    // Parser next state and single record
    always_comb begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cell_next    = cell_reg;
        rem_next     = rem_reg;
        layer_next   = layer_reg;
        low_next     = low_reg;
        rec_load     = 1'b0;
        rec          = '0;
        burst_next   = burst_reg;
        bcell_next   = bcell_reg;
        bheight_next = bheight_reg;
        brow_next    = brow_reg;
        bcol_next    = bcol_reg;

        // Burst advance on each taken record
        if (m_fire && burst_reg) begin
            bcell_next = bcell_reg + 1'b1;
            if (bcell_reg == tgbd_pkg::CELL_LAST) begin
                burst_next = 1'b0;
            end
        end

        if (s_fire) begin
            row_next = cur_row;
            col_next = cur_col;
            unique case (cur_phase)
                tgbd_pkg::PH_TYPE: begin
                    cell_next  = '0;
                    rem_next   = 8'd0;
                    layer_next = 8'd0;
                    if (s_data.data_byte == tgbd_pkg::TYPE_BYTE_FLAT) begin
                        type_next  = tgbd_pkg::BT_FLAT;
                        phase_next = tgbd_pkg::PH_FLAT_LO;
                    end else if (s_data.data_byte == tgbd_pkg::TYPE_BYTE_COMPLEX) begin
                        type_next  = tgbd_pkg::BT_COMPLEX;
                        phase_next = tgbd_pkg::PH_WORD_LO;
                    end else begin
                        type_next  = tgbd_pkg::BT_MULTI;
                        phase_next = tgbd_pkg::PH_COUNT;
                    end
                end
                tgbd_pkg::PH_FLAT_LO: begin
                    low_next   = s_data.data_byte;
                    phase_next = tgbd_pkg::PH_FLAT_HI;
                end
                tgbd_pkg::PH_FLAT_HI: begin
                    // First record now, the other 63 from the burst
                    rec_load        = 1'b1;
                    rec.cell_x      = tgbd_pkg::cell_coord(cur_row, 3'd0);
                    rec.cell_z      = tgbd_pkg::cell_coord(cur_col, 3'd0);
                    rec.layer_index = 8'd0;
                    rec.height      = word;
                    rec.nswe_bits   = tgbd_pkg::NSWE_FLAT;
                    rec.last        = 1'b0;
                    burst_next      = 1'b1;
                    bcell_next      = tgbd_pkg::CELL_W'(1);
                    bheight_next    = word;
                    brow_next       = cur_row;
                    bcol_next       = cur_col;
                    cell_next       = '0;
                    row_next        = nb_row;
                    col_next        = nb_col;
                    phase_next      = nb_phase;
                end
                tgbd_pkg::PH_COUNT: begin
                    rem_next   = s_data.data_byte;
                    layer_next = 8'd0;
                    if (s_data.data_byte == 8'd0) begin
                        // Empty cell: no record
                        if (cell_end) begin
                            cell_next  = '0;
                            row_next   = nb_row;
                            col_next   = nb_col;
                            phase_next = nb_phase;
                        end else begin
                            cell_next  = cell_reg + 1'b1;
                            phase_next = (type_reg == tgbd_pkg::BT_COMPLEX) ?
                                         tgbd_pkg::PH_WORD_LO : tgbd_pkg::PH_COUNT;
                        end
                    end else begin
                        phase_next = tgbd_pkg::PH_WORD_LO;
                    end
                end
                tgbd_pkg::PH_WORD_LO: begin
                    low_next   = s_data.data_byte;
                    phase_next = tgbd_pkg::PH_WORD_HI;
                end
                tgbd_pkg::PH_WORD_HI: begin
                    rec_load        = 1'b1;
                    rec.cell_x      = tgbd_pkg::cell_coord(cur_row, cell_reg[5:3]);
                    rec.cell_z      = tgbd_pkg::cell_coord(cur_col, cell_reg[2:0]);
                    rec.height      = tgbd_pkg::decode_height(word);
                    rec.nswe_bits   = word[3:0];
                    rec.last        = 1'b1;
                    if (type_reg == tgbd_pkg::BT_COMPLEX) begin
                        rec.layer_index = 8'd0;
                    end else begin
                        rec.layer_index = layer_reg;
                        layer_next      = layer_reg + 8'd1;
                        rem_next        = rem_dec;
                    end
                    if (type_reg == tgbd_pkg::BT_COMPLEX || rem_dec == 8'd0) begin
                        if (cell_end) begin
                            cell_next  = '0;
                            row_next   = nb_row;
                            col_next   = nb_col;
                            phase_next = nb_phase;
                        end else begin
                            cell_next  = cell_reg + 1'b1;
                            phase_next = (type_reg == tgbd_pkg::BT_COMPLEX) ?
                                         tgbd_pkg::PH_WORD_LO : tgbd_pkg::PH_COUNT;
                        end
                    end else begin
                        phase_next = tgbd_pkg::PH_WORD_LO;
                    end
                end
                default: begin
                    // Region finished: bytes dropped until restart
                    phase_next = tgbd_pkg::PH_DONE;
                end
            endcase
        end
    end

    // Next burst record of a flat block
    always_comb begin
        burst_rec             = '0;
        burst_rec.cell_x      = tgbd_pkg::cell_coord(brow_reg, bcell_reg[5:3]);
        burst_rec.cell_z      = tgbd_pkg::cell_coord(bcol_reg, bcell_reg[2:0]);
        burst_rec.layer_index = 8'd0;
        burst_rec.height      = bheight_reg;
        burst_rec.nswe_bits   = tgbd_pkg::NSWE_FLAT;
        burst_rec.last        = (bcell_reg == tgbd_pkg::CELL_LAST);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tgbd_pkg::PH_TYPE;
            type_reg    <= tgbd_pkg::BT_FLAT;
            row_reg     <= '0;
            col_reg     <= '0;
            cell_reg    <= '0;
            rem_reg     <= 8'd0;
            layer_reg   <= 8'd0;
            low_reg     <= 8'd0;
            burst_reg   <= 1'b0;
            bcell_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cell_reg  <= cell_next;
            rem_reg   <= rem_next;
            layer_reg <= layer_next;
            low_reg   <= low_next;
            burst_reg <= burst_next;
            bcell_reg <= bcell_next;
            if (s_fire && rec_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_fire && !burst_reg) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        bheight_reg <= bheight_next;
        brow_reg    <= brow_next;
        bcol_reg    <= bcol_next;
        if (s_fire && rec_load) begin
            m_data_reg <= rec;
        end else if (m_fire && burst_reg) begin
            m_data_reg <= burst_rec;
        end
    end

    // Checks
    `TGBD_ASSERT(a_burst_has_beat, aclk, aresetn, burst_reg |-> m_valid_reg,
        "flat burst running without a held output beat")
    `TGBD_ASSERT(a_burst_blocks_input, aclk, aresetn, burst_reg |-> !s_ready,
        "input accepted during a flat burst")
    `TGBD_ASSERT(a_burst_ends_last,
        aclk, aresetn,
        (burst_reg && m_fire && bcell_reg == tgbd_pkg::CELL_LAST) |=>
            (!burst_reg && m_valid_reg && m_data_reg.last),
        "flat burst did not end on a last record")
    `TGBD_ASSERT(a_done_is_silent,
        aclk, aresetn,
        (s_fire && !s_data.restart && phase_reg == tgbd_pkg::PH_DONE) |=> !m_valid_reg,
        "record produced after the final block")

endmodule
